// ===== rtl/core/bms_pkg.sv =====
// Shared types and constants of the buzzer melody sequencer.
// No dependencies; every other file of the core imports this package.
`default_nettype none

package bms_pkg;

  // Operation codes carried by an input word
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  // Note table entry kinds; the fourth code plays as a pause
  localparam logic [1:0] KIND_TONE  = 2'd0;
  localparam logic [1:0] KIND_PAUSE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Configuration register indexes
  localparam int         CFG_INDEX_W     = 1;
  localparam int         CFG_DATA_W      = 16;
  localparam logic [0:0] REG_BEAT_LENGTH = 1'b0;
  localparam logic [0:0] REG_TONE_LEVEL  = 1'b1;

  // Field widths and fixed values
  localparam int          ADDR_W            = 6;
  localparam logic [3:0]  MAX_LEVEL         = 4'd10;
  localparam logic [15:0] BEAT_LENGTH_RESET = 16'd250;
  localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pitch;
    logic [7:0]  beats;
  } note_entry_t;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] tone_pitch;
    logic [3:0]  tone_volume;
    logic        playing;
    logic        finished;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bms_if.sv =====
// Valid/ready channel interfaces of the buzzer melody sequencer: command input,
// tone result output and configuration writes. Depends on bms_pkg.
`default_nettype none

interface bms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [5:0]  note_address;
  logic [1:0]  note_kind;
  logic [15:0] note_pitch;
  logic [7:0]  note_beats;
  logic [7:0]  repeat_count;

  modport source (output valid, operation, note_address, note_kind, note_pitch,
                  note_beats, repeat_count, input ready);
  modport sink   (input valid, operation, note_address, note_kind, note_pitch,
                  note_beats, repeat_count, output ready);
endinterface

interface bms_out_if;
  logic        valid;
  logic        ready;
  logic        tone_on;
  logic [15:0] tone_pitch;
  logic [3:0]  tone_volume;
  logic        playing;
  logic        finished;

  modport source (output valid, tone_on, tone_pitch, tone_volume, playing, finished,
                  input ready);
  modport sink   (input valid, tone_on, tone_pitch, tone_volume, playing, finished,
                  output ready);
endinterface

interface bms_cfg_if;
  import bms_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bms_note_mem.sv =====
// Note table memory: one write port, one read port with registered read data.
// Depends on bms_pkg for the entry type.
`default_nettype none

module bms_note_mem #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  bms_pkg::note_entry_t      wr_entry,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output bms_pkg::note_entry_t      rd_entry
);
  import bms_pkg::*;

  note_entry_t mem [DEPTH];

  // Store a written entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Registered read, updated only when rd_en is set
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bms_result_fifo.sv =====
// Two-word result queue that drives the tone output channel.
// Depends on bms_pkg and bms_out_if.
`default_nettype none

module bms_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bms_pkg::result_t push_data,
  output logic             full,
  bms_out_if.source        tone_out
);
  import bms_pkg::*;

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  result_t    head;

  assign pop  = tone_out.valid && tone_out.ready;
  assign full = (count == 2'd2);
  assign head = slot[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Hold pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  assign tone_out.valid       = (count != 2'd0);
  assign tone_out.tone_on     = head.tone_on;
  assign tone_out.tone_pitch  = head.tone_pitch;
  assign tone_out.tone_volume = head.tone_volume;
  assign tone_out.playing     = head.playing;
  assign tone_out.finished    = head.finished;

endmodule

`default_nettype wire

// ===== rtl/core/buzzer_melody_sequencer_core.sv =====
// Buzzer melody sequencer core: plays notes from a TABLE_DEPTH-entry note table.
// A command word is a tick (one millisecond), start, stop or note write; each
// gives one result word with the tone drive state after it. Tick words that do
// not end a note, stop and note writes push their result when taken; start and
// a tick that ends a note push it once the next entry comes from the registered
// read port of the note table. Results queue in a two-word buffer, so commands
// keep flowing while the output side stalls until the buffer fills. The note
// table has no reset: an entry must be written before playback reaches it.
// Depends on bms_pkg, bms_if, bms_note_mem and bms_result_fifo.
`default_nettype none

module buzzer_melody_sequencer_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  bms_in_if.sink     note_in,
  bms_cfg_if.sink    cfg,
  bms_out_if.source  tone_out
);
  import bms_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  // Reduce a command address modulo the table depth, one shifted compare per bit
  function automatic logic [AW-1:0] wrap_addr(input logic [ADDR_W-1:0] a);
    logic [15:0] r;
    r = 16'(a);
    for (int k = ADDR_W - 1; k >= 0; k--) begin
      if (r >= 16'(TABLE_DEPTH << k)) begin
        r = r - 16'(TABLE_DEPTH << k);
      end
    end
    return r[AW-1:0];
  endfunction

  // Playback state
  logic [AW-1:0] melody_base,   melody_base_next;
  logic [AW-1:0] note_position, note_position_next;
  logic [15:0]   elapsed_ms,    elapsed_ms_next;
  logic [7:0]    repeats_left,  repeats_left_next;
  logic          melody_active, melody_active_next;
  logic          drive_on,      drive_on_next;
  logic [15:0]   drive_pitch,   drive_pitch_next;
  logic [3:0]    drive_volume,  drive_volume_next;
  // Cached copies of the current and base entries
  logic [1:0]    cur_kind,      cur_kind_next;
  logic [7:0]    cur_beats,     cur_beats_next;
  note_entry_t   base_entry,    base_entry_next;
  // Read in flight
  logic          b_pend,        b_pend_next;
  logic          b_start,       b_start_next;
  // Configuration
  logic [15:0]   beat_length_ms;
  logic [3:0]    tone_level;

  op_t           op;
  logic          in_fire;
  logic [23:0]   limit;
  logic [15:0]   el_inc;
  logic          tick_live;
  logic          tick_adv;
  logic [AW-1:0] next_pos;
  logic [AW-1:0] cmd_addr;
  logic          needs_read;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  note_entry_t   wr_entry;
  note_entry_t   rd_entry;
  logic          push;
  result_t       push_data;
  logic          fifo_full;

  // Accept a command only with no read in flight and room for its result
  assign note_in.ready = !b_pend && !fifo_full;
  assign in_fire       = note_in.valid && note_in.ready;
  assign op            = op_t'(note_in.operation);

  // Note end check for a tick
  assign limit     = 24'(beat_length_ms) * 24'(cur_beats);
  assign el_inc    = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 16'd1;
  assign tick_live = melody_active && (cur_kind != KIND_END);
  assign tick_adv  = tick_live && (24'(el_inc) >= limit);
  assign next_pos  = (note_position == AW'(TABLE_DEPTH - 1)) ? '0
                                                             : note_position + AW'(1);
  assign cmd_addr  = wrap_addr(note_in.note_address);

  // Table access
  assign needs_read = (op == OP_START) || ((op == OP_TICK) && tick_adv);
  assign rd_en      = in_fire && needs_read;
  assign rd_addr    = (op == OP_START) ? cmd_addr : next_pos;
  assign wr_en      = in_fire && (op == OP_WRITE);
  assign wr_entry   = '{kind: note_in.note_kind, pitch: note_in.note_pitch,
                        beats: note_in.note_beats};

  bms_note_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_note_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (cmd_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // Next playback state: finish a read in flight, or act on a new command
  always_comb begin
    note_entry_t play;
    note_entry_t base_e;
    melody_base_next   = melody_base;
    note_position_next = note_position;
    elapsed_ms_next    = elapsed_ms;
    repeats_left_next  = repeats_left;
    melody_active_next = melody_active;
    drive_on_next      = drive_on;
    drive_pitch_next   = drive_pitch;
    drive_volume_next  = drive_volume;
    cur_kind_next      = cur_kind;
    cur_beats_next     = cur_beats;
    base_entry_next    = base_entry;
    b_pend_next        = 1'b0;
    b_start_next       = 1'b0;
    push               = 1'b0;
    play               = rd_entry;
    base_e             = b_start ? rd_entry : base_entry;

    if (b_pend) begin
      if (b_start) begin
        base_entry_next = rd_entry;
      end
      // Restart at the base on an end marker with repeats left
      if ((rd_entry.kind == KIND_END) && (repeats_left != 8'd0)) begin
        repeats_left_next  = repeats_left - 8'd1;
        note_position_next = melody_base;
        play               = base_e;
        if (base_e.kind == KIND_END) begin
          repeats_left_next = 8'd0;
        end
      end
      cur_kind_next  = play.kind;
      cur_beats_next = play.beats;
      // Drive a tone, silence a pause, hold at an end marker
      if (play.kind == KIND_TONE) begin
        drive_on_next     = 1'b1;
        drive_pitch_next  = play.pitch;
        drive_volume_next = tone_level;
      end else if (play.kind != KIND_END) begin
        drive_on_next = 1'b0;
      end
      push = 1'b1;
    end else if (in_fire) begin
      b_pend_next  = needs_read;
      b_start_next = (op == OP_START);
      unique case (op)
        OP_TICK: begin
          if (tick_adv) begin
            elapsed_ms_next    = 16'd0;
            note_position_next = next_pos;
          end else if (tick_live) begin
            elapsed_ms_next = el_inc;
          end
          push = !tick_adv;
        end
        OP_START: begin
          melody_base_next   = cmd_addr;
          note_position_next = cmd_addr;
          elapsed_ms_next    = 16'd0;
          repeats_left_next  = note_in.repeat_count;
          melody_active_next = 1'b1;
        end
        OP_STOP: begin
          melody_active_next = 1'b0;
          drive_on_next      = 1'b0;
          push               = 1'b1;
        end
        OP_WRITE: begin
          // Keep the caches in step with the table
          if (cmd_addr == note_position) begin
            cur_kind_next  = note_in.note_kind;
            cur_beats_next = note_in.note_beats;
          end
          if (cmd_addr == melody_base) begin
            base_entry_next = wr_entry;
          end
          push = 1'b1;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  // Result word from the updated state
  always_comb begin
    push_data.tone_on     = drive_on_next;
    push_data.tone_pitch  = drive_on_next ? drive_pitch_next : 16'd0;
    push_data.tone_volume = drive_on_next ? drive_volume_next : 4'd0;
    push_data.playing     = melody_active_next;
    push_data.finished    = !melody_active_next ||
                            ((repeats_left_next == 8'd0) && (cur_kind_next == KIND_END));
  end

  // Commit playback state
  always_ff @(posedge clk) begin
    if (rst) begin
      melody_base   <= '0;
      note_position <= '0;
      elapsed_ms    <= 16'd0;
      repeats_left  <= 8'd0;
      melody_active <= 1'b0;
      drive_on      <= 1'b0;
      drive_pitch   <= 16'd0;
      drive_volume  <= 4'd0;
      cur_kind      <= KIND_TONE;
      cur_beats     <= 8'd0;
      b_pend        <= 1'b0;
      b_start       <= 1'b0;
    end else begin
      melody_base   <= melody_base_next;
      note_position <= note_position_next;
      elapsed_ms    <= elapsed_ms_next;
      repeats_left  <= repeats_left_next;
      melody_active <= melody_active_next;
      drive_on      <= drive_on_next;
      drive_pitch   <= drive_pitch_next;
      drive_volume  <= drive_volume_next;
      cur_kind      <= cur_kind_next;
      cur_beats     <= cur_beats_next;
      b_pend        <= b_pend_next;
      b_start       <= b_start_next;
    end
  end

  // Base entry cache carries table contents only
  always_ff @(posedge clk) begin
    base_entry <= base_entry_next;
  end

  // Configuration writes; volume saturates at its maximum
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_length_ms <= BEAT_LENGTH_RESET;
      tone_level     <= MAX_LEVEL;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_BEAT_LENGTH: beat_length_ms <= cfg.data;
        REG_TONE_LEVEL:  tone_level     <= (cfg.data[3:0] > MAX_LEVEL) ? MAX_LEVEL
                                                                       : cfg.data[3:0];
        default:         beat_length_ms <= beat_length_ms;
      endcase
    end
  end

  bms_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .tone_out  (tone_out)
  );

  // A table read completes in the cycle after it was issued
  a_read_one_cycle: assert property (@(posedge clk) disable iff (rst)
    b_pend |=> !b_pend)
    else $error("table read still pending after one cycle");

  // No command is taken while a read is in flight
  a_interlock: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !b_pend)
    else $error("command accepted during a pending table read");

  // A result never lands in a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_full)
    else $error("result pushed into a full queue");

  // Silence carries no pitch or volume
  a_silent_word: assert property (@(posedge clk) disable iff (rst)
    push && !push_data.tone_on |-> (push_data.tone_pitch == 16'd0) &&
                                   (push_data.tone_volume == 4'd0))
    else $error("silent result word with pitch or volume");

endmodule

`default_nettype wire
